// ===== hw/rtl/affine_2d_point_transform_top_defines.svh =====
// ----------------------------------------------------------------------------
// Affine 2D point transform - assertion macros
// Shared property templates for the block's checker.
// ----------------------------------------------------------------------------
`ifndef AFFINE_2D_POINT_TRANSFORM_TOP_DEFINES_SVH
`define AFFINE_2D_POINT_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication
`define AFF2D_ASSERT_IMPL(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("aff2d same-cycle check failed");

// next-cycle implication
`define AFF2D_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("aff2d next-cycle check failed");

`endif

// ===== hw/rtl/aff2d_pkg.sv =====
// ----------------------------------------------------------------------------
// Affine 2D point transform - package
// Request codes, fixed widths, angle constants and shared struct types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aff2d_pkg;

   localparam int FUNC_W  = 3;
   localparam int DATA_W  = 32;
   localparam int ANGLE_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_POINT     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_ROTATE    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SCALE     = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_IDENTITY  = 3'd4;

   // angle units: 1/64 degree
   localparam int QUARTER_UNITS = 5760;
   localparam int TURN_UNITS    = 23040;
   localparam int RED_W         = 15;
   localparam int QUARTER_W     = 13;

   // 5760 = 128 * 45; divide by 45 through a reciprocal
   localparam int              QUARTER_SHIFT = 7;
   localparam int              RECIP_W       = 27;
   localparam logic [RECIP_W-1:0] DIV45_RECIP = 27'd95443718;
   localparam int              DIV45_SHIFT   = 32;

   // pi/2 in Q2.30 and Taylor term divisors (2k)(2k+1)
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int          TERM_COUNT  = 10;
   localparam logic [63:0] TERM_DIVISORS [TERM_COUNT] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
      64'd156, 64'd210, 64'd272, 64'd342, 64'd420
   };

   // input register plus five angle stages
   localparam int PIPE_DEPTH = 6;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [DATA_W-1:0]  value_a;
      logic signed [DATA_W-1:0]  value_b;
      logic signed [ANGLE_W-1:0] angle;
   } item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sin_val;
      logic signed [DATA_W-1:0] cos_val;
   } trig_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic                     overflow;
   } result_type;

endpackage

// ===== hw/rtl/aff2d_angle.sv =====
// ----------------------------------------------------------------------------
// Affine 2D point transform - angle unit
// Five-stage sine/cosine lookup: reduce, scale, divide, table read, fold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aff2d_angle #(
   parameter int FRACTION_BITS    = 16,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               advance,
   input  logic signed [aff2d_pkg::ANGLE_W-1:0] angle,
   output aff2d_pkg::trig_type                trig
);

   localparam int TAB_W  = FRACTION_BITS + 1;
   localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
   localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int RD_W   = aff2d_pkg::QUARTER_W + ADDR_W;
   localparam int N_W    = RD_W - aff2d_pkg::QUARTER_SHIFT;
   localparam int PR_W   = N_W + aff2d_pkg::RECIP_W;
   localparam int EXT_W  = aff2d_pkg::ANGLE_W + 1;
   localparam int DW     = aff2d_pkg::DATA_W;

   localparam logic signed [EXT_W-1:0] TURN_S     = EXT_W'(aff2d_pkg::TURN_UNITS);
   localparam logic signed [EXT_W-1:0] TWO_TURN_S = EXT_W'(2 * aff2d_pkg::TURN_UNITS);
   localparam int RED_W_L = aff2d_pkg::RED_W;
   localparam logic [RED_W_L-1:0] Q1 = RED_W_L'(aff2d_pkg::QUARTER_UNITS);
   localparam logic [RED_W_L-1:0] Q2 = RED_W_L'(2 * aff2d_pkg::QUARTER_UNITS);
   localparam logic [RED_W_L-1:0] Q3 = RED_W_L'(3 * aff2d_pkg::QUARTER_UNITS);

   function automatic logic [TAB_W-1:0] quarter_sine(input int idx);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x    = (aff2d_pkg::HALF_PI_Q30 * 64'(idx)) / SINE_TABLE_DEPTH;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= aff2d_pkg::TERM_COUNT; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / aff2d_pkg::TERM_DIVISORS[k-1];
         if (k[0]) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      return TAB_W'((64'(sum) + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
   endfunction

   logic [TAB_W-1:0] sine_rom [0:SINE_TABLE_DEPTH];

   for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
      assign sine_rom[g] = quarter_sine(g);
   end

   // stage 1: reduce to one turn and split into quadrant and remainder
   logic signed [EXT_W-1:0]          ang_ext;
   logic [RED_W_L-1:0]               red;
   logic [1:0]                       quad_in;
   logic [aff2d_pkg::QUARTER_W-1:0]  rem_in;
   logic [1:0]                       st1_quad_ff;
   logic [aff2d_pkg::QUARTER_W-1:0]  st1_rem_ff;

   always_comb begin
      ang_ext = EXT_W'(angle);
      priority if (ang_ext < -TURN_S) begin
         red = RED_W_L'(ang_ext + TWO_TURN_S);
      end else if (ang_ext < 0) begin
         red = RED_W_L'(ang_ext + TURN_S);
      end else if (ang_ext >= TURN_S) begin
         red = RED_W_L'(ang_ext - TURN_S);
      end else begin
         red = RED_W_L'(ang_ext);
      end
      priority if (red >= Q3) begin
         quad_in = 2'd3;
         rem_in  = aff2d_pkg::QUARTER_W'(red - Q3);
      end else if (red >= Q2) begin
         quad_in = 2'd2;
         rem_in  = aff2d_pkg::QUARTER_W'(red - Q2);
      end else if (red >= Q1) begin
         quad_in = 2'd1;
         rem_in  = aff2d_pkg::QUARTER_W'(red - Q1);
      end else begin
         quad_in = 2'd0;
         rem_in  = aff2d_pkg::QUARTER_W'(red);
      end
   end

   // stage 2: remainder * depth / 128
   logic [RD_W-1:0] scaled;
   logic [N_W-1:0]  st2_num_ff;
   logic [1:0]      st2_quad_ff;

   assign scaled = RD_W'(st1_rem_ff) * RD_W'(SINE_TABLE_DEPTH);

   // stage 3: divide by 45
   logic [PR_W-1:0]  recip_prod;
   logic [IDX_W-1:0] st3_idx_ff;
   logic [1:0]       st3_quad_ff;

   assign recip_prod = PR_W'(st2_num_ff) * PR_W'(aff2d_pkg::DIV45_RECIP);

   // stage 4: table read
   logic [TAB_W-1:0] st4_sin_ff;
   logic [TAB_W-1:0] st4_cos_ff;
   logic [1:0]       st4_quad_ff;

   // stage 5: quadrant fold
   logic signed [DW-1:0] s_ext;
   logic signed [DW-1:0] c_ext;
   aff2d_pkg::trig_type  trig_in;
   aff2d_pkg::trig_type  trig_ff;

   always_comb begin
      s_ext = signed'(DW'(st4_sin_ff));
      c_ext = signed'(DW'(st4_cos_ff));
      unique case (st4_quad_ff)
         2'd0: begin
            trig_in.sin_val = s_ext;
            trig_in.cos_val = c_ext;
         end
         2'd1: begin
            trig_in.sin_val = c_ext;
            trig_in.cos_val = -s_ext;
         end
         2'd2: begin
            trig_in.sin_val = -s_ext;
            trig_in.cos_val = -c_ext;
         end
         default: begin
            trig_in.sin_val = -c_ext;
            trig_in.cos_val = s_ext;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_quad_ff <= quad_in;
         st1_rem_ff  <= rem_in;
         st2_num_ff  <= scaled[RD_W-1:aff2d_pkg::QUARTER_SHIFT];
         st2_quad_ff <= st1_quad_ff;
         st3_idx_ff  <= recip_prod[aff2d_pkg::DIV45_SHIFT +: IDX_W];
         st3_quad_ff <= st2_quad_ff;
         st4_sin_ff  <= sine_rom[ADDR_W'(st3_idx_ff)];
         st4_cos_ff  <= sine_rom[ADDR_W'(SINE_TABLE_DEPTH) - ADDR_W'(st3_idx_ff)];
         st4_quad_ff <= st3_quad_ff;
         trig_ff     <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

// ===== hw/rtl/aff2d_matrix.sv =====
// ----------------------------------------------------------------------------
// Affine 2D point transform - matrix unit
// Holds the six matrix entries and overflow flag; applies one request a cycle while update is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aff2d_matrix #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  aff2d_pkg::item_type   item,
   input  aff2d_pkg::trig_type   trig,
   output aff2d_pkg::result_type result
);

   localparam int DW   = aff2d_pkg::DATA_W;
   localparam int PW   = 2 * DW;
   localparam int ROWS = 2;

   localparam logic signed [DW-1:0] ONE_Q  = DW'(1) << FRACTION_BITS;
   localparam logic signed [PW-1:0] SAT_HI = PW'(64'sh7fff_ffff);
   localparam logic signed [PW-1:0] SAT_LO = -PW'(64'sh8000_0000);
   localparam logic signed [PW-1:0] HALF_Q = PW'(1) <<< (FRACTION_BITS - 1);

   typedef struct packed {
      logic                 ovf;
      logic signed [DW-1:0] value;
   } sat_type;

   function automatic logic signed [PW-1:0] mulq(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      return (p + HALF_Q) >>> FRACTION_BITS;
   endfunction

   function automatic sat_type sat32(input logic signed [PW-1:0] v);
      sat_type s;
      if (v > SAT_HI) begin
         s.ovf   = 1'b1;
         s.value = SAT_HI[DW-1:0];
      end else if (v < SAT_LO) begin
         s.ovf   = 1'b1;
         s.value = SAT_LO[DW-1:0];
      end else begin
         s.ovf   = 1'b0;
         s.value = v[DW-1:0];
      end
      return s;
   endfunction

   // per row: col0, col1 are the linear part, col2 the offset
   logic signed [DW-1:0] col0_ff [ROWS];
   logic signed [DW-1:0] col1_ff [ROWS];
   logic signed [DW-1:0] col2_ff [ROWS];
   logic signed [DW-1:0] col0_in [ROWS];
   logic signed [DW-1:0] col1_in [ROWS];
   logic signed [DW-1:0] col2_in [ROWS];
   logic                 sticky_ff;
   logic                 sticky_in;

   logic signed [DW-1:0] op_a;
   logic signed [DW-1:0] op_b;
   logic signed [PW-1:0] prod_a [ROWS];
   logic signed [PW-1:0] prod_b [ROWS];
   logic signed [PW-1:0] prod_c [ROWS];
   logic signed [PW-1:0] prod_d [ROWS];
   sat_type              rot_x  [ROWS];
   sat_type              rot_y  [ROWS];
   sat_type              lin    [ROWS];
   sat_type              sca_x  [ROWS];
   sat_type              sca_y  [ROWS];
   logic                 rot_ovf;
   logic                 sca_ovf;
   logic                 lin_ovf;

   always_comb begin
      op_a = (item.func == aff2d_pkg::FUNC_ROTATE) ? trig.cos_val : item.value_a;
      op_b = (item.func == aff2d_pkg::FUNC_ROTATE) ? trig.sin_val : item.value_b;
      for (int r = 0; r < ROWS; r++) begin
         prod_a[r] = mulq(col0_ff[r], op_a);
         prod_b[r] = mulq(col1_ff[r], op_b);
         prod_c[r] = mulq(col0_ff[r], trig.sin_val);
         prod_d[r] = mulq(col1_ff[r], trig.cos_val);
         rot_x[r]  = sat32(prod_a[r] - prod_b[r]);
         rot_y[r]  = sat32(prod_c[r] + prod_d[r]);
         lin[r]    = sat32(prod_a[r] + prod_b[r] + PW'(col2_ff[r]));
         sca_x[r]  = sat32(prod_a[r]);
         sca_y[r]  = sat32(prod_b[r]);
      end
      rot_ovf = rot_x[0].ovf | rot_y[0].ovf | rot_x[1].ovf | rot_y[1].ovf;
      sca_ovf = sca_x[0].ovf | sca_y[0].ovf | sca_x[1].ovf | sca_y[1].ovf;
      lin_ovf = lin[0].ovf | lin[1].ovf;
   end

   always_comb begin
      col0_in   = col0_ff;
      col1_in   = col1_ff;
      col2_in   = col2_ff;
      sticky_in = sticky_ff;
      result.out_x    = lin[0].value;
      result.out_y    = lin[1].value;
      result.overflow = sticky_ff | lin_ovf;
      unique case (item.func)
         aff2d_pkg::FUNC_POINT: begin
            sticky_in = 1'b0;
         end
         aff2d_pkg::FUNC_ROTATE: begin
            for (int r = 0; r < ROWS; r++) begin
               col0_in[r] = rot_x[r].value;
               col1_in[r] = rot_y[r].value;
            end
            sticky_in = sticky_ff | rot_ovf;
         end
         aff2d_pkg::FUNC_SCALE: begin
            for (int r = 0; r < ROWS; r++) begin
               col0_in[r] = sca_x[r].value;
               col1_in[r] = sca_y[r].value;
            end
            sticky_in = sticky_ff | sca_ovf;
         end
         aff2d_pkg::FUNC_TRANSLATE: begin
            for (int r = 0; r < ROWS; r++) begin
               col2_in[r] = lin[r].value;
            end
            sticky_in = sticky_ff | lin_ovf;
         end
         aff2d_pkg::FUNC_IDENTITY: begin
            col0_in = '{ONE_Q, '0};
            col1_in = '{'0, ONE_Q};
            col2_in = '{'0, '0};
         end
         default: begin
            sticky_in = sticky_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col0_ff   <= '{ONE_Q, '0};
         col1_ff   <= '{'0, ONE_Q};
         col2_ff   <= '{'0, '0};
         sticky_ff <= 1'b0;
      end else if (update) begin
         col0_ff   <= col0_in;
         col1_ff   <= col1_in;
         col2_ff   <= col2_in;
         sticky_ff <= sticky_in;
      end
   end

endmodule

// ===== hw/rtl/affine_2d_point_transform_top.sv =====
// ----------------------------------------------------------------------------
// Affine 2D point transform - top level
// Requests (func, value_a, value_b, angle) enter on the req_ channel under
// valid/stall. Rotate, scale and translate requests update a 2x3 Q-format
// matrix; identity restores it; a point request returns out_x, out_y and
// the overflow flag on the rsp_ channel. Other requests return nothing.
// A point request passes the input register and five angle-lookup stages
// (reduce, scale, reciprocal divide, sine table read, quadrant fold), and
// then the matrix stage writes its response to the output register.
// Throughput is one request per cycle while no response is held by
// rsp_stall; the matrix stage updates all entries at once.
// Reset returns the matrix to identity, clears the overflow flag and
// empties the pipeline. While rsp_stall holds a waiting response, the
// whole pipeline holds and req_stall is raised; otherwise req_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_2d_point_transform_top #(
   parameter int FRACTION_BITS    = 16,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [aff2d_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [aff2d_pkg::DATA_W-1:0] req_value_a,
   input  logic signed [aff2d_pkg::DATA_W-1:0] req_value_b,
   input  logic signed [aff2d_pkg::ANGLE_W-1:0] req_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [aff2d_pkg::DATA_W-1:0] rsp_out_x,
   output logic signed [aff2d_pkg::DATA_W-1:0] rsp_out_y,
   output logic                                rsp_overflow
);

   localparam int LAST = aff2d_pkg::PIPE_DEPTH - 1;

   logic                  advance;
   logic                  valid_ff [aff2d_pkg::PIPE_DEPTH];
   aff2d_pkg::item_type   item_ff  [aff2d_pkg::PIPE_DEPTH];
   aff2d_pkg::item_type   req_item;
   aff2d_pkg::trig_type   trig;
   aff2d_pkg::result_type result;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   aff2d_pkg::result_type rsp_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign req_item.func    = req_func;
   assign req_item.value_a = req_value_a;
   assign req_item.value_b = req_value_b;
   assign req_item.angle   = req_angle;

   assign rsp_valid_in = valid_ff[LAST] && (item_ff[LAST].func == aff2d_pkg::FUNC_POINT);

   aff2d_angle #(
      .FRACTION_BITS    (FRACTION_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_angle (
      .clock   (clock),
      .advance (advance),
      .angle   (item_ff[0].angle),
      .trig    (trig)
   );

   aff2d_matrix #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_matrix (
      .clock  (clock),
      .reset  (reset),
      .update (advance && valid_ff[LAST]),
      .item   (item_ff[LAST]),
      .trig   (trig),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < aff2d_pkg::PIPE_DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < aff2d_pkg::PIPE_DEPTH; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff[0] <= req_item;
         for (int i = 1; i < aff2d_pkg::PIPE_DEPTH; i++) begin
            item_ff[i] <= item_ff[i-1];
         end
         if (rsp_valid_in) begin
            rsp_ff <= result;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_x    = rsp_ff.out_x;
   assign rsp_out_y    = rsp_ff.out_y;
   assign rsp_overflow = rsp_ff.overflow;

endmodule

// ===== hw/rtl/aff2d_checker.sv =====
// ----------------------------------------------------------------------------
// Affine 2D point transform - port checker
// Watches the top-level ports for reset, flow-control and hold behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "affine_2d_point_transform_top_defines.svh"

module aff2d_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [aff2d_pkg::FUNC_W-1:0]        req_func,
   input logic signed [aff2d_pkg::DATA_W-1:0] req_value_a,
   input logic signed [aff2d_pkg::DATA_W-1:0] req_value_b,
   input logic signed [aff2d_pkg::ANGLE_W-1:0] req_angle,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [aff2d_pkg::DATA_W-1:0] rsp_out_x,
   input logic signed [aff2d_pkg::DATA_W-1:0] rsp_out_y,
   input logic                                rsp_overflow
);

   // reset empties the output register
   `AFF2D_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)

   // the pipeline is still empty right after reset is released
   `AFF2D_ASSERT_NEXT(a_no_rsp_after_reset, clock, 1'b0, reset ##1 !reset, !rsp_valid)

   // requests are held off only by a blocked response
   `AFF2D_ASSERT_IMPL(a_stall_only_on_block, clock, reset, req_stall, rsp_valid && rsp_stall)

   // a stalled response holds
   `AFF2D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_overflow))

endmodule

bind affine_2d_point_transform_top aff2d_checker u_checker (.*);

// ===== test/tb_affine_2d_point_transform_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Affine 2D point transform - testbench
// Drives matrix updates and points through the request channel with random
// gaps and response stalls, predicts every point in a local fixed-point model
// of the matrix and sine lookup, and checks each response in order.
// ----------------------------------------------------------------------------

module tb_affine_2d_point_transform_top;

   localparam int FRACTION_BITS    = 16;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int RANDOM_ITEMS     = 1850;
   localparam int MAX_REPORTS      = 10;

   localparam logic [aff2d_pkg::FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [aff2d_pkg::FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [aff2d_pkg::FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

   localparam logic signed [aff2d_pkg::DATA_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [aff2d_pkg::DATA_W-1:0] Q_MIN  = 32'sh8000_0000;
   localparam logic signed [aff2d_pkg::DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
   localparam longint                   WORD_MAX = 64'sd2147483647;
   localparam longint                   WORD_MIN = -64'sd2147483648;

   typedef struct {
      aff2d_pkg::item_type   req;
      bit                    typed;
      aff2d_pkg::result_type want;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_stall;
   aff2d_pkg::item_type                 cur_req   = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [aff2d_pkg::DATA_W-1:0] rsp_out_x;
   logic signed [aff2d_pkg::DATA_W-1:0] rsp_out_y;
   logic                                rsp_overflow;

   bit                    cur_typed = 1'b0;
   aff2d_pkg::result_type cur_want  = '0;
   bit                    calm      = 1'b0;

   // predictor state
   logic signed [aff2d_pkg::DATA_W-1:0] xform [6];
   bit                                  sticky_ovf;
   int                                  sine_lut [0:SINE_TABLE_DEPTH];

   aff2d_pkg::result_type pending_points [$];
   step_type              directed_steps [$];

   int error_count = 0;
   int n_point = 0, n_point_ovf = 0, n_rotate = 0, n_scale = 0;
   int n_translate = 0, n_identity = 0, n_spare = 0, n_checked = 0;

   affine_2d_point_transform_top #(
      .FRACTION_BITS   (FRACTION_BITS),
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (cur_req.func),
      .req_value_a (cur_req.value_a),
      .req_value_b (cur_req.value_b),
      .req_angle   (cur_req.angle),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_overflow(rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- model

   function automatic int quarter_sine(input int unsigned i);
      longint unsigned x, term;
      longint          acc;
      x    = (aff2d_pkg::HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 10; k++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      return int'(($unsigned(acc) + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
   endfunction

   function automatic longint round_product(input int a, input int b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
   endfunction

   function automatic logic signed [aff2d_pkg::DATA_W-1:0] clamp_word(input longint v,
                                                                       inout bit ovf);
      if (v > WORD_MAX) begin
         ovf = 1'b1;
         return Q_MAX;
      end
      if (v < WORD_MIN) begin
         ovf = 1'b1;
         return Q_MIN;
      end
      return v[aff2d_pkg::DATA_W-1:0];
   endfunction

   function automatic void load_identity();
      xform[0] = Q_ONE; xform[1] = '0; xform[2] = '0;
      xform[3] = '0;    xform[4] = Q_ONE; xform[5] = '0;
   endfunction

   // returns 1 when the request yields a point response
   function automatic bit apply_request(input aff2d_pkg::item_type it,
                                        output aff2d_pkg::result_type res);
      bit  ovf;
      int  ang, quad, rem, idx, s0, c0, s, c;
      logic signed [aff2d_pkg::DATA_W-1:0] p0, p1;
      ovf = 1'b0;
      res = '0;
      case (it.func)
         aff2d_pkg::FUNC_POINT: begin
            res.out_x = clamp_word(round_product(xform[0], it.value_a)
                                   + round_product(xform[1], it.value_b)
                                   + longint'(xform[2]), ovf);
            res.out_y = clamp_word(round_product(xform[3], it.value_a)
                                   + round_product(xform[4], it.value_b)
                                   + longint'(xform[5]), ovf);
            res.overflow = ovf | sticky_ovf;
            sticky_ovf = 1'b0;
            return 1'b1;
         end
         aff2d_pkg::FUNC_ROTATE: begin
            ang = int'(it.angle) % aff2d_pkg::TURN_UNITS;
            if (ang < 0) ang = ang + aff2d_pkg::TURN_UNITS;
            quad = ang / aff2d_pkg::QUARTER_UNITS;
            rem  = ang % aff2d_pkg::QUARTER_UNITS;
            idx  = (rem * SINE_TABLE_DEPTH) / aff2d_pkg::QUARTER_UNITS;
            s0   = sine_lut[idx];
            c0   = sine_lut[SINE_TABLE_DEPTH - idx];
            case (quad)
               0:       begin s = s0;  c = c0;  end
               1:       begin s = c0;  c = -s0; end
               2:       begin s = -s0; c = -c0; end
               default: begin s = -c0; c = s0;  end
            endcase
            for (int row = 0; row < 2; row++) begin
               p0 = xform[row * 3];
               p1 = xform[row * 3 + 1];
               xform[row * 3]     = clamp_word(round_product(p0, c) - round_product(p1, s), ovf);
               xform[row * 3 + 1] = clamp_word(round_product(p0, s) + round_product(p1, c), ovf);
            end
         end
         aff2d_pkg::FUNC_SCALE: begin
            for (int row = 0; row < 2; row++) begin
               xform[row * 3]     = clamp_word(round_product(xform[row * 3], it.value_a), ovf);
               xform[row * 3 + 1] = clamp_word(round_product(xform[row * 3 + 1], it.value_b),
                                               ovf);
            end
         end
         aff2d_pkg::FUNC_TRANSLATE: begin
            for (int row = 0; row < 2; row++) begin
               xform[row * 3 + 2] = clamp_word(round_product(xform[row * 3], it.value_a)
                                               + round_product(xform[row * 3 + 1], it.value_b)
                                               + longint'(xform[row * 3 + 2]), ovf);
            end
         end
         aff2d_pkg::FUNC_IDENTITY: load_identity();
         default: ;
      endcase
      if (ovf) sticky_ovf = 1'b1;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic note_error(input string msg, input aff2d_pkg::result_type want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t mismatch: %s; expected x=%0d y=%0d ovf=%0b, got x=%0d y=%0d ovf=%0b",
                  $realtime, msg, want.out_x, want.out_y, want.overflow,
                  rsp_out_x, rsp_out_y, rsp_overflow);
   endtask

   always @(posedge clock) begin
      aff2d_pkg::result_type want, got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (pending_points.size() == 0) begin
               note_error("response with no request waiting", '0);
            end else begin
               want = pending_points.pop_front();
               if (rsp_out_x !== want.out_x) note_error("out_x", want);
               if (rsp_out_y !== want.out_y) note_error("out_y", want);
               if (rsp_overflow !== want.overflow) note_error("overflow", want);
            end
         end
         if (req_valid && !req_stall) begin
            case (cur_req.func)
               aff2d_pkg::FUNC_POINT:     n_point++;
               aff2d_pkg::FUNC_ROTATE:    n_rotate++;
               aff2d_pkg::FUNC_SCALE:     n_scale++;
               aff2d_pkg::FUNC_TRANSLATE: n_translate++;
               aff2d_pkg::FUNC_IDENTITY:  n_identity++;
               default:                   n_spare++;
            endcase
            if (apply_request(cur_req, got)) begin
               if (got.overflow) n_point_ovf++;
               pending_points.push_back(cur_typed ? cur_want : got);
            end
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 21);

   // ---------------------------------------------------------------- stimulus

   function automatic logic signed [aff2d_pkg::DATA_W-1:0] rand_word(input bit near_one);
      int unsigned                         mode;
      logic signed [aff2d_pkg::DATA_W-1:0] w;
      mode = $urandom_range(9);
      if (mode == 0) begin
         w = $urandom;
      end else if (mode == 1) begin
         case ($urandom_range(3))
            0:       w = Q_MAX;
            1:       w = Q_MIN;
            2:       w = '0;
            default: w = '1;
         endcase
      end else if (near_one) begin
         w = $urandom_range(32'h0002_4000, 32'h0000_4000);
         if ($urandom_range(4) == 0) w = -w;
      end else begin
         w = $urandom_range(32'h01FF_FFFF) - 32'h0100_0000;
      end
      return w;
   endfunction

   task automatic add_step(input logic [aff2d_pkg::FUNC_W-1:0] f,
                           input logic signed [aff2d_pkg::DATA_W-1:0] a,
                           input logic signed [aff2d_pkg::DATA_W-1:0] b,
                           input logic signed [aff2d_pkg::ANGLE_W-1:0] ang, input bit typed,
                           input logic signed [aff2d_pkg::DATA_W-1:0] wx = '0,
                           input logic signed [aff2d_pkg::DATA_W-1:0] wy = '0,
                           input bit wovf = 1'b0);
      step_type st;
      st.req.func      = f;
      st.req.value_a   = a;
      st.req.value_b   = b;
      st.req.angle     = ang;
      st.typed         = typed;
      st.want.out_x    = wx;
      st.want.out_y    = wy;
      st.want.overflow = wovf;
      directed_steps.push_back(st);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic present_request(input aff2d_pkg::item_type r, input bit typed,
                                  input aff2d_pkg::result_type w);
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      cur_req   <= r;
      cur_typed <= typed;
      cur_want  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_points.size() != 0) @(negedge clock);
   endtask

   initial begin
      aff2d_pkg::item_type rq;
      int                  counted;
      int                  pick;

      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) sine_lut[i] = quarter_sine(i);
      load_identity();
      sticky_ovf = 1'b0;

      add_step(aff2d_pkg::FUNC_POINT, '0, '0, '0, 1'b1, '0, '0, 1'b0);
      add_step(aff2d_pkg::FUNC_POINT, Q_MAX, Q_MIN, '0, 1'b1, Q_MAX, Q_MIN, 1'b0);
      add_step(FUNC_SPARE_LO, '1, '1, '1, 1'b0);
      add_step(aff2d_pkg::FUNC_POINT, -32'sd1, 32'sd1, '0, 1'b1, -32'sd1, 32'sd1, 1'b0);
      add_step(aff2d_pkg::FUNC_SCALE, 2 * Q_ONE, 2 * Q_ONE, '0, 1'b0);
      add_step(aff2d_pkg::FUNC_POINT, Q_MAX, 32'sd1, '0, 1'b1, Q_MAX, 32'sd2, 1'b1);
      add_step(aff2d_pkg::FUNC_POINT, 32'sd1, 32'sd1, '0, 1'b1, 32'sd2, 32'sd2, 1'b0);
      add_step(aff2d_pkg::FUNC_IDENTITY, '0, '0, '0, 1'b0);
      add_step(aff2d_pkg::FUNC_TRANSLATE, Q_MAX, Q_MIN, '0, 1'b0);
      add_step(aff2d_pkg::FUNC_TRANSLATE, Q_ONE, '0, '0, 1'b0);
      // identity keeps the sticky flag
      add_step(aff2d_pkg::FUNC_IDENTITY, '0, '0, '0, 1'b0);
      add_step(aff2d_pkg::FUNC_POINT, '0, '0, '0, 1'b1, '0, '0, 1'b1);
      add_step(aff2d_pkg::FUNC_ROTATE, '0, '0, 16'sd0, 1'b0);
      add_step(aff2d_pkg::FUNC_POINT, Q_ONE, Q_ONE, '0, 1'b0);
      add_step(aff2d_pkg::FUNC_ROTATE, '0, '0, 16'sd5760, 1'b0);
      add_step(aff2d_pkg::FUNC_ROTATE, '0, '0, 16'sd11520, 1'b0);
      add_step(aff2d_pkg::FUNC_ROTATE, '0, '0, 16'sd17280, 1'b0);
      add_step(aff2d_pkg::FUNC_ROTATE, '0, '0, 16'sd23040, 1'b0);
      add_step(aff2d_pkg::FUNC_ROTATE, '0, '0, -16'sd23040, 1'b0);
      add_step(aff2d_pkg::FUNC_ROTATE, '0, '0, 16'sh7FFF, 1'b0);
      add_step(aff2d_pkg::FUNC_ROTATE, '0, '0, 16'sh8000, 1'b0);
      add_step(aff2d_pkg::FUNC_POINT, 3 * Q_ONE, -Q_ONE, '0, 1'b0);
      add_step(aff2d_pkg::FUNC_SCALE, Q_MIN, Q_MAX, '0, 1'b0);
      add_step(aff2d_pkg::FUNC_POINT, Q_MIN, Q_MIN, '0, 1'b0);
      add_step(FUNC_SPARE_MID, Q_MAX, Q_MIN, 16'sh7FFF, 1'b0);
      add_step(FUNC_SPARE_HI, Q_MIN, Q_MAX, 16'sh8000, 1'b0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_steps[i])
         present_request(directed_steps[i].req, directed_steps[i].typed,
                         directed_steps[i].want);
      wait_for_drain();

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         calm = (counted >= 700 && counted < 1000);
         if (counted == 1300) wait_for_drain();
         pick       = $urandom_range(99);
         rq.value_a = rand_word(1'b0);
         rq.value_b = rand_word(1'b0);
         rq.angle   = $urandom;
         if (pick < 40) begin
            rq.func = aff2d_pkg::FUNC_POINT;
         end else if (pick < 55) begin
            rq.func = aff2d_pkg::FUNC_ROTATE;
            if ($urandom_range(4) != 0)
               rq.angle = $urandom_range(2 * aff2d_pkg::TURN_UNITS) - aff2d_pkg::TURN_UNITS;
         end else if (pick < 70) begin
            rq.func    = aff2d_pkg::FUNC_SCALE;
            rq.value_a = rand_word(1'b1);
            rq.value_b = rand_word(1'b1);
         end else if (pick < 83) begin
            rq.func = aff2d_pkg::FUNC_TRANSLATE;
         end else if (pick < 94) begin
            rq.func = aff2d_pkg::FUNC_IDENTITY;
         end else begin
            rq.func = $urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO);
         end
         present_request(rq, 1'b0, '0);
         counted++;
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (aff2d_pkg::PIPE_DEPTH + 4) @(posedge clock);

      $display("Covered %0d points (%0d with overflow), %0d rotates, %0d scales, %0d translates",
               n_point, n_point_ovf, n_rotate, n_scale, n_translate);
      $display("plus %0d identity restores and %0d unused codes; %0d responses checked, %0d errors",
               n_identity, n_spare, n_checked, error_count);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
